>>> hdl/gavf_pkg.sv
// Shared widths, limits and register indexes of the gated altitude/velocity filter.
// No dependencies; imported by gavf_div and gated_altitude_velocity_filter.
package gavf_pkg;

  localparam int TICK_W = 32;
  localparam int ALT_W  = 27;
  localparam int VEL_W  = 16;
  localparam int GATE_W = 20;
  localparam int CONV_W = 16;
  localparam int DT_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Residuals, altitude sums and the velocity accumulator all fit in 28 signed bits.
  localparam int WIDE_W = 28;

  // Serial divider: the dividend leaves two bits per cycle, so DIV_NUM_W is even.
  localparam int DIV_NUM_W = 28;
  localparam int DIV_DEN_W = 10;

  localparam logic signed [WIDE_W-1:0] ALT_MIN  = -28'sd1000000;
  localparam logic signed [WIDE_W-1:0] ALT_MAX  = 28'sd50000000;
  localparam logic signed [WIDE_W-1:0] VEL_LIM  = 28'sd25000;
  localparam logic signed [WIDE_W-1:0] VEL_NLIM = -28'sd25000;

  localparam logic [TICK_W-1:0] DT_MAX = 32'd100;
  localparam logic [DT_W-1:0]   DT_CAP = 7'd100;
  localparam logic [DT_W-1:0]   DT_MIN = 7'd1;

  localparam logic [GATE_W-1:0]    GATE_DEFAULT = 20'd1000;
  localparam logic [DIV_DEN_W-1:0] MS_PER_S     = 10'd1000;
  localparam logic [DIV_DEN_W-1:0] PCT_DEN      = 10'd100;

  localparam logic [CFG_IDX_W-1:0] REG_BARO_GATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GPS_GATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CONV  = 2'd2;

endpackage

>>> hdl/gated_altitude_velocity_filter.sv
// Gated alpha-beta altitude/velocity filter, top level; uses gavf_pkg and gavf_div.
// The result beat is registered after one radix-4 divider pass for propagation and
// one more divider pass per gated update.
// Input is stalled while an item is in flight; it is taken again while a result waits.
// Reset (rst, synchronous): state zeroed, both gates pass, registers to their defaults.
module gated_altitude_velocity_filter import gavf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [GATE_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [TICK_W-1:0]        now_ms,
  input  logic                     baro_valid,
  input  logic signed [ALT_W-1:0]  baro_alt_mm,
  input  logic                     gps_valid,
  input  logic signed [ALT_W-1:0]  gps_alt_mm,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ALT_W-1:0]  altitude_mm,
  output logic signed [VEL_W-1:0]  velocity_mm_s,
  output logic                     baro_gate_pass,
  output logic                     gps_gate_pass,
  output logic                     all_gates_ok,
  output logic                     converged
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_PROP      = 7'b0000010,
    S_PROP_WAIT = 7'b0000100,
    S_RESID     = 7'b0001000,
    S_GATE      = 7'b0010000,
    S_UPD_WAIT  = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_t;

  state_t state;

  logic [GATE_W-1:0] baro_gate;
  logic [GATE_W-1:0] gps_gate;
  logic [CONV_W-1:0] min_conv;
  logic [TICK_W-1:0] conv_ms;

  logic [TICK_W-1:0]       last_tick;
  logic signed [ALT_W-1:0] altitude;
  logic signed [VEL_W-1:0] velocity;
  logic [TICK_W-1:0]       filter_time;
  logic                    baro_pass;
  logic                    gps_pass;

  logic [DT_W-1:0]          dt;
  logic                     baro_v;
  logic                     gps_v;
  logic [ALT_W-1:0]         baro_meas;
  logic [ALT_W-1:0]         gps_meas;
  logic                     use_gps;
  logic                     neg;
  logic [WIDE_W-1:0]        resid_mag;
  logic signed [WIDE_W-1:0] vel_acc;

  logic                 a_start;
  logic                 b_start;
  logic [DIV_NUM_W-1:0] a_num;
  logic [DIV_NUM_W-1:0] b_num;
  logic [DIV_DEN_W-1:0] a_den;
  logic [DIV_DEN_W-1:0] b_den;
  logic                 a_done;
  logic                 b_done;
  logic [DIV_NUM_W-1:0] a_quo;
  logic [DIV_NUM_W-1:0] b_quo;

  logic                     in_accept;
  logic                     out_free;
  logic [TICK_W-1:0]        tick_diff;
  logic [DT_W-1:0]          dt_next;
  logic [TICK_W:0]          filter_sum;
  logic [VEL_W-1:0]         vel_abs;
  logic [21:0]              prop_prod;
  logic [ALT_W-1:0]         meas;
  logic                     meas_valid;
  logic signed [WIDE_W-1:0] resid;
  logic [GATE_W-1:0]        gate;
  logic [GATE_W-1:0]        thr;
  logic                     gate_ok;
  logic [WIDE_W-1:0]        alt_mul;
  logic [WIDE_W-1:0]        vel_mul;
  logic [WIDE_W-1:0]        alt_delta;
  logic signed [WIDE_W-1:0] alt_sum;
  logic signed [ALT_W-1:0]  alt_sat;
  logic [WIDE_W-1:0]        vel_delta;
  logic signed [VEL_W-1:0]  vel_clamp;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    tick_diff = now_ms - last_tick;
    if (tick_diff == '0) begin
      dt_next = DT_MIN;
    end else if (tick_diff > DT_MAX) begin
      dt_next = DT_CAP;
    end else begin
      dt_next = tick_diff[DT_W-1:0];
    end
  end

  assign filter_sum = {1'b0, filter_time} + {{(TICK_W + 1 - DT_W){1'b0}}, dt};

  assign vel_abs   = velocity[VEL_W-1] ? -velocity : velocity;
  assign prop_prod = vel_abs[VEL_W-2:0] * dt;

  assign meas       = use_gps ? gps_meas : baro_meas;
  assign meas_valid = use_gps ? gps_v : baro_v;
  assign resid      = {meas[ALT_W-1], meas} - {altitude[ALT_W-1], altitude};

  assign gate    = use_gps ? gps_gate : baro_gate;
  assign thr     = (gate == '0) ? GATE_DEFAULT : gate;
  assign gate_ok = (resid_mag <= {{(WIDE_W - GATE_W){1'b0}}, thr});

  // Gains by shift and add: 35 and 80 for the barometer, 10 and 20 for GPS.
  // A passing residual is below 2^20, so the products never overflow.
  assign alt_mul = use_gps ? (resid_mag << 3) + (resid_mag << 1)
                           : (resid_mag << 5) + (resid_mag << 1) + resid_mag;
  assign vel_mul = use_gps ? (resid_mag << 4) + (resid_mag << 2)
                           : (resid_mag << 6) + (resid_mag << 4);

  // Quotients are magnitudes; applying the sign afterward truncates toward zero.
  assign alt_delta = neg ? -a_quo : a_quo;
  assign vel_delta = neg ? -b_quo : b_quo;
  assign alt_sum   = {altitude[ALT_W-1], altitude} + alt_delta;

  always_comb begin
    if (alt_sum < ALT_MIN) begin
      alt_sat = ALT_MIN[ALT_W-1:0];
    end else if (alt_sum > ALT_MAX) begin
      alt_sat = ALT_MAX[ALT_W-1:0];
    end else begin
      alt_sat = alt_sum[ALT_W-1:0];
    end
  end

  always_comb begin
    if (vel_acc > VEL_LIM) begin
      vel_clamp = VEL_LIM[VEL_W-1:0];
    end else if (vel_acc < VEL_NLIM) begin
      vel_clamp = VEL_NLIM[VEL_W-1:0];
    end else begin
      vel_clamp = vel_acc[VEL_W-1:0];
    end
  end

  always_comb begin
    a_start = 1'b0;
    b_start = 1'b0;
    a_num   = {{(DIV_NUM_W - 22){1'b0}}, prop_prod};
    a_den   = MS_PER_S;
    b_num   = vel_mul;
    b_den   = {{(DIV_DEN_W - DT_W){1'b0}}, dt};
    case (state)
      S_PROP: begin
        a_start = 1'b1;
      end
      S_GATE: begin
        a_start = gate_ok;
        b_start = gate_ok;
        a_num   = alt_mul;
        a_den   = PCT_DEN;
      end
      default: begin
      end
    endcase
  end

  gavf_div u_div_alt (
    .clk   (clk),
    .rst   (rst),
    .start (a_start),
    .num   (a_num),
    .den   (a_den),
    .done  (a_done),
    .quo   (a_quo)
  );

  gavf_div u_div_vel (
    .clk   (clk),
    .rst   (rst),
    .start (b_start),
    .num   (b_num),
    .den   (b_den),
    .done  (b_done),
    .quo   (b_quo)
  );

  // 1000 * m as 1024m - 32m + 8m.
  always_ff @(posedge clk) begin
    conv_ms <= ({{(TICK_W - CONV_W){1'b0}}, min_conv} << 10)
             - ({{(TICK_W - CONV_W){1'b0}}, min_conv} << 5)
             + ({{(TICK_W - CONV_W){1'b0}}, min_conv} << 3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baro_gate <= GATE_DEFAULT;
      gps_gate  <= GATE_DEFAULT;
      min_conv  <= 16'd10;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BARO_GATE: baro_gate <= cfg_data;
        REG_GPS_GATE:  gps_gate  <= cfg_data;
        REG_MIN_CONV:  min_conv  <= cfg_data[CONV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_tick   <= '0;
      altitude    <= '0;
      velocity    <= '0;
      filter_time <= '0;
      baro_pass   <= 1'b1;
      gps_pass    <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            last_tick <= now_ms;
            state     <= S_PROP;
          end
        end
        S_PROP: begin
          filter_time <= filter_sum[TICK_W] ? '1 : filter_sum[TICK_W-1:0];
          state       <= S_PROP_WAIT;
        end
        S_PROP_WAIT: begin
          if (a_done) begin
            altitude <= alt_sat;
            state    <= S_RESID;
          end
        end
        S_RESID: begin
          if (meas_valid) begin
            state <= S_GATE;
          end else if (use_gps) begin
            state <= S_FINISH;
          end else begin
            state <= S_RESID;
          end
        end
        S_GATE: begin
          if (use_gps) begin
            gps_pass <= gate_ok;
          end else begin
            baro_pass <= gate_ok;
          end
          if (gate_ok) begin
            state <= S_UPD_WAIT;
          end else if (use_gps) begin
            state <= S_FINISH;
          end else begin
            state <= S_RESID;
          end
        end
        S_UPD_WAIT: begin
          if (a_done && b_done) begin
            altitude <= alt_sat;
            state    <= use_gps ? S_FINISH : S_RESID;
          end
        end
        S_FINISH: begin
          velocity <= vel_clamp;
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          dt        <= dt_next;
          baro_v    <= baro_valid;
          gps_v     <= gps_valid;
          baro_meas <= baro_alt_mm;
          gps_meas  <= gps_alt_mm;
          use_gps   <= 1'b0;
        end
      end
      S_PROP: begin
        neg     <= velocity[VEL_W-1];
        vel_acc <= {{(WIDE_W - VEL_W){velocity[VEL_W-1]}}, velocity};
      end
      S_RESID: begin
        neg       <= resid[WIDE_W-1];
        resid_mag <= resid[WIDE_W-1] ? -resid : resid;
        if (!meas_valid) begin
          use_gps <= 1'b1;
        end
      end
      S_GATE: begin
        if (!gate_ok) begin
          use_gps <= 1'b1;
        end
      end
      S_UPD_WAIT: begin
        if (a_done && b_done) begin
          vel_acc <= vel_acc + vel_delta;
          use_gps <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      altitude_mm    <= altitude;
      velocity_mm_s  <= vel_clamp;
      baro_gate_pass <= baro_pass;
      gps_gate_pass  <= gps_pass;
      all_gates_ok   <= baro_pass && gps_pass;
      converged      <= (filter_time >= conv_ms);
    end
  end

endmodule

>>> hdl/gavf_div.sv
// Radix-4 restoring divider, unsigned, two quotient bits per cycle.
// Depends on gavf_pkg for the dividend and divisor widths.
module gavf_div import gavf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int STEPS = DIV_NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DIV_NUM_W-1:0] q;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] d;
  logic [DIV_DEN_W+1:0] d3;
  logic [CNT_W-1:0]     cnt;

  logic [DIV_DEN_W+1:0] rem4;
  logic [DIV_DEN_W+1:0] d1x;
  logic [DIV_DEN_W+1:0] d2x;
  logic [DIV_DEN_W+1:0] sub;
  logic [DIV_DEN_W+1:0] diff;
  logic [1:0]           digit;

  // The partial remainder stays below d, so the shifted-in window is below 4d.
  always_comb begin
    rem4 = {rem, q[DIV_NUM_W-1 -: 2]};
    d1x  = {2'b00, d};
    d2x  = {1'b0, d, 1'b0};
    if (rem4 >= d3) begin
      digit = 2'd3;
      sub   = d3;
    end else if (rem4 >= d2x) begin
      digit = 2'd2;
      sub   = d2x;
    end else if (rem4 >= d1x) begin
      digit = 2'd1;
      sub   = d1x;
    end else begin
      digit = 2'd0;
      sub   = '0;
    end
    diff = rem4 - sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
      d3  <= {2'b00, den} + {1'b0, den, 1'b0};
    end else if (cnt != '0) begin
      q   <= {q[DIV_NUM_W-3:0], digit};
      rem <= diff[DIV_DEN_W-1:0];
    end
  end

  assign quo = q;

endmodule
